FILE: hw/rtl/mi4_pkg.sv
package mi4_pkg;

    // Controller states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_OPA,
        ST_OPB,
        ST_MUL,
        ST_COMMIT,
        ST_CHECK,
        ST_DIV,
        ST_EMIT,
        ST_ECHO
    } state_t;

    // What happens to the accumulator when a micro-op finishes.
    typedef enum logic [1:0] {
        DST_NONE,
        DST_MID,
        DST_DET,
        DST_COF
    } dest_t;

    // Operand codes: 0 to 15 are the stored elements, then the intermediate vectors.
    localparam logic [4:0] OPD_S0 = 5'd16;
    localparam logic [4:0] OPD_S1 = 5'd17;
    localparam logic [4:0] OPD_S2 = 5'd18;
    localparam logic [4:0] OPD_T0 = 5'd19;
    localparam logic [4:0] OPD_T1 = 5'd20;
    localparam logic [4:0] OPD_T2 = 5'd21;
    localparam logic [4:0] OPD_U0 = 5'd22;
    localparam logic [4:0] OPD_U1 = 5'd23;
    localparam logic [4:0] OPD_U2 = 5'd24;
    localparam logic [4:0] OPD_V0 = 5'd25;
    localparam logic [4:0] OPD_V1 = 5'd26;
    localparam logic [4:0] OPD_V2 = 5'd27;
    localparam logic [4:0] OPD_MID_BASE = 5'd16;
    localparam int unsigned MID_COUNT = 12;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    // Program positions that the controller assertions check, and the last element index.
    localparam logic [6:0] DET_PC  = 7'd29;
    localparam logic [6:0] LAST_PC = 7'd77;
    localparam logic [3:0] LAST_IDX = 4'd15;

    typedef struct packed {
        logic [4:0] a;
        logic [4:0] b;
        logic       neg;
        dest_t      dest;
        logic [3:0] mid;
    } mop_t;

    typedef struct packed {
        logic       load_we;
        logic [3:0] load_idx;
        logic [4:0] sel;
        logic       ld_a;
        logic       ld_b;
        logic       neg;
        logic       mul_step;
        logic       acc_clr;
        logic       commit_mid;
        logic [3:0] mid_idx;
        logic       commit_det;
        logic       div_start;
        logic       emit_cof;
        logic       emit_echo;
        logic [3:0] idx;
    } cmd_t;

    typedef struct packed {
        logic singular;
        logic div_done;
    } sts_t;

    function automatic mop_t mk(input logic [4:0] a, input logic [4:0] b, input logic neg,
                                input dest_t dest, input logic [4:0] m);
        mop_t r;
        r.a    = a;
        r.b    = b;
        r.neg  = neg;
        r.dest = dest;
        r.mid  = 4'(m - OPD_MID_BASE);
        return r;
    endfunction

    // Micro-program: each step adds or subtracts one product to the accumulator.
    function automatic mop_t micro_op(input logic [6:0] pc);
        mop_t r;
        case (pc)
            // s = a x b
            7'd0:  r = mk(5'd1, 5'd6, OP_ADD, DST_NONE, OPD_S0);
            7'd1:  r = mk(5'd2, 5'd5, OP_SUB, DST_MID, OPD_S0);
            7'd2:  r = mk(5'd2, 5'd4, OP_ADD, DST_NONE, OPD_S1);
            7'd3:  r = mk(5'd0, 5'd6, OP_SUB, DST_MID, OPD_S1);
            7'd4:  r = mk(5'd0, 5'd5, OP_ADD, DST_NONE, OPD_S2);
            7'd5:  r = mk(5'd1, 5'd4, OP_SUB, DST_MID, OPD_S2);
            // t = c x d
            7'd6:  r = mk(5'd9, 5'd14, OP_ADD, DST_NONE, OPD_T0);
            7'd7:  r = mk(5'd10, 5'd13, OP_SUB, DST_MID, OPD_T0);
            7'd8:  r = mk(5'd10, 5'd12, OP_ADD, DST_NONE, OPD_T1);
            7'd9:  r = mk(5'd8, 5'd14, OP_SUB, DST_MID, OPD_T1);
            7'd10: r = mk(5'd8, 5'd13, OP_ADD, DST_NONE, OPD_T2);
            7'd11: r = mk(5'd9, 5'd12, OP_SUB, DST_MID, OPD_T2);
            // u = a*y - b*x
            7'd12: r = mk(5'd0, 5'd7, OP_ADD, DST_NONE, OPD_U0);
            7'd13: r = mk(5'd4, 5'd3, OP_SUB, DST_MID, OPD_U0);
            7'd14: r = mk(5'd1, 5'd7, OP_ADD, DST_NONE, OPD_U1);
            7'd15: r = mk(5'd5, 5'd3, OP_SUB, DST_MID, OPD_U1);
            7'd16: r = mk(5'd2, 5'd7, OP_ADD, DST_NONE, OPD_U2);
            7'd17: r = mk(5'd6, 5'd3, OP_SUB, DST_MID, OPD_U2);
            // v = c*w - d*z
            7'd18: r = mk(5'd8, 5'd15, OP_ADD, DST_NONE, OPD_V0);
            7'd19: r = mk(5'd12, 5'd11, OP_SUB, DST_MID, OPD_V0);
            7'd20: r = mk(5'd9, 5'd15, OP_ADD, DST_NONE, OPD_V1);
            7'd21: r = mk(5'd13, 5'd11, OP_SUB, DST_MID, OPD_V1);
            7'd22: r = mk(5'd10, 5'd15, OP_ADD, DST_NONE, OPD_V2);
            7'd23: r = mk(5'd14, 5'd11, OP_SUB, DST_MID, OPD_V2);
            // det = s.v + t.u
            7'd24: r = mk(OPD_S0, OPD_V0, OP_ADD, DST_NONE, OPD_S0);
            7'd25: r = mk(OPD_S1, OPD_V1, OP_ADD, DST_NONE, OPD_S0);
            7'd26: r = mk(OPD_S2, OPD_V2, OP_ADD, DST_NONE, OPD_S0);
            7'd27: r = mk(OPD_T0, OPD_U0, OP_ADD, DST_NONE, OPD_S0);
            7'd28: r = mk(OPD_T1, OPD_U1, OP_ADD, DST_NONE, OPD_S0);
            7'd29: r = mk(OPD_T2, OPD_U2, OP_ADD, DST_DET, OPD_S0);
            // Cofactors of result row 0
            7'd30: r = mk(5'd5, OPD_V2, OP_ADD, DST_NONE, OPD_S0);
            7'd31: r = mk(5'd6, OPD_V1, OP_SUB, DST_NONE, OPD_S0);
            7'd32: r = mk(OPD_T0, 5'd7, OP_ADD, DST_COF, OPD_S0);
            7'd33: r = mk(OPD_V1, 5'd2, OP_ADD, DST_NONE, OPD_S0);
            7'd34: r = mk(OPD_V2, 5'd1, OP_SUB, DST_NONE, OPD_S0);
            7'd35: r = mk(OPD_T0, 5'd3, OP_SUB, DST_COF, OPD_S0);
            7'd36: r = mk(5'd13, OPD_U2, OP_ADD, DST_NONE, OPD_S0);
            7'd37: r = mk(5'd14, OPD_U1, OP_SUB, DST_NONE, OPD_S0);
            7'd38: r = mk(OPD_S0, 5'd15, OP_ADD, DST_COF, OPD_S0);
            7'd39: r = mk(OPD_U1, 5'd10, OP_ADD, DST_NONE, OPD_S0);
            7'd40: r = mk(OPD_U2, 5'd9, OP_SUB, DST_NONE, OPD_S0);
            7'd41: r = mk(OPD_S0, 5'd11, OP_SUB, DST_COF, OPD_S0);
            // Cofactors of result row 1
            7'd42: r = mk(5'd6, OPD_V0, OP_ADD, DST_NONE, OPD_S0);
            7'd43: r = mk(5'd4, OPD_V2, OP_SUB, DST_NONE, OPD_S0);
            7'd44: r = mk(OPD_T1, 5'd7, OP_ADD, DST_COF, OPD_S0);
            7'd45: r = mk(OPD_V2, 5'd0, OP_ADD, DST_NONE, OPD_S0);
            7'd46: r = mk(OPD_V0, 5'd2, OP_SUB, DST_NONE, OPD_S0);
            7'd47: r = mk(OPD_T1, 5'd3, OP_SUB, DST_COF, OPD_S0);
            7'd48: r = mk(5'd14, OPD_U0, OP_ADD, DST_NONE, OPD_S0);
            7'd49: r = mk(5'd12, OPD_U2, OP_SUB, DST_NONE, OPD_S0);
            7'd50: r = mk(OPD_S1, 5'd15, OP_ADD, DST_COF, OPD_S0);
            7'd51: r = mk(OPD_U2, 5'd8, OP_ADD, DST_NONE, OPD_S0);
            7'd52: r = mk(OPD_U0, 5'd10, OP_SUB, DST_NONE, OPD_S0);
            7'd53: r = mk(OPD_S1, 5'd11, OP_SUB, DST_COF, OPD_S0);
            // Cofactors of result row 2
            7'd54: r = mk(5'd4, OPD_V1, OP_ADD, DST_NONE, OPD_S0);
            7'd55: r = mk(5'd5, OPD_V0, OP_SUB, DST_NONE, OPD_S0);
            7'd56: r = mk(OPD_T2, 5'd7, OP_ADD, DST_COF, OPD_S0);
            7'd57: r = mk(OPD_V0, 5'd1, OP_ADD, DST_NONE, OPD_S0);
            7'd58: r = mk(OPD_V1, 5'd0, OP_SUB, DST_NONE, OPD_S0);
            7'd59: r = mk(OPD_T2, 5'd3, OP_SUB, DST_COF, OPD_S0);
            7'd60: r = mk(5'd12, OPD_U1, OP_ADD, DST_NONE, OPD_S0);
            7'd61: r = mk(5'd13, OPD_U0, OP_SUB, DST_NONE, OPD_S0);
            7'd62: r = mk(OPD_S2, 5'd15, OP_ADD, DST_COF, OPD_S0);
            7'd63: r = mk(OPD_U0, 5'd9, OP_ADD, DST_NONE, OPD_S0);
            7'd64: r = mk(OPD_U1, 5'd8, OP_SUB, DST_NONE, OPD_S0);
            7'd65: r = mk(OPD_S2, 5'd11, OP_SUB, DST_COF, OPD_S0);
            // Right column: -b.t, a.t, -d.s, c.s
            7'd66: r = mk(5'd4, OPD_T0, OP_SUB, DST_NONE, OPD_S0);
            7'd67: r = mk(5'd5, OPD_T1, OP_SUB, DST_NONE, OPD_S0);
            7'd68: r = mk(5'd6, OPD_T2, OP_SUB, DST_COF, OPD_S0);
            7'd69: r = mk(5'd0, OPD_T0, OP_ADD, DST_NONE, OPD_S0);
            7'd70: r = mk(5'd1, OPD_T1, OP_ADD, DST_NONE, OPD_S0);
            7'd71: r = mk(5'd2, OPD_T2, OP_ADD, DST_COF, OPD_S0);
            7'd72: r = mk(5'd12, OPD_S0, OP_SUB, DST_NONE, OPD_S0);
            7'd73: r = mk(5'd13, OPD_S1, OP_SUB, DST_NONE, OPD_S0);
            7'd74: r = mk(5'd14, OPD_S2, OP_SUB, DST_COF, OPD_S0);
            7'd75: r = mk(5'd8, OPD_S0, OP_ADD, DST_NONE, OPD_S0);
            7'd76: r = mk(5'd9, OPD_S1, OP_ADD, DST_NONE, OPD_S0);
            7'd77: r = mk(5'd10, OPD_S2, OP_ADD, DST_COF, OPD_S0);
            default: r = mk(5'd0, 5'd0, OP_ADD, DST_NONE, OPD_S0);
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/mi4_div.sv
module mi4_div #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    parameter int ACC_W     = 4 * 32 + 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] cof,
    input  logic signed [ACC_W-1:0] det,
    output logic [WORD_BITS-1:0]    quo,
    output logic                    done
);

    localparam int NUM_W = ACC_W + 2 * FRAC_BITS + 2;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int RW    = ACC_W + 1;

    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] q_reg;
    logic [RW-1:0]    den_reg;
    logic [RW-1:0]    rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic             done_reg;

    logic [ACC_W-1:0] cof_mag;
    logic [ACC_W-1:0] det_mag;
    logic [RW:0]      trial;
    logic [RW:0]      diff;
    logic             ge;
    logic             hi_nz;
    logic             exact_lim;

    // Magnitudes of the operands; the sign is handled separately.
    assign cof_mag = cof[ACC_W-1] ? ACC_W'(-cof) : ACC_W'(cof);
    assign det_mag = det[ACC_W-1] ? ACC_W'(-det) : ACC_W'(det);

    // One restoring step: shift in the next numerator bit and try the subtract.
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end

    // Numerator is 2*|cof|*2^(2F) + |det| over 2*|det|, which rounds half away from zero.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= (NUM_W'(cof_mag) << (2 * FRAC_BITS + 1)) + NUM_W'(det_mag);
            den_reg <= {det_mag, 1'b0};
            rem_reg <= '0;
            q_reg   <= '0;
            neg_reg <= cof[ACC_W-1] ^ det[ACC_W-1];
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? diff[RW-1:0] : trial[RW-1:0];
            q_reg   <= {q_reg[NUM_W-2:0], ge};
        end
    end

    // Saturate to the signed word range.
    assign hi_nz     = |q_reg[NUM_W-1:WORD_BITS-1];
    assign exact_lim = q_reg[WORD_BITS-1] && !(|q_reg[NUM_W-1:WORD_BITS])
                       && !(|q_reg[WORD_BITS-2:0]);

    always_comb
    begin
        if (!neg_reg)
        begin
            quo = hi_nz ? {1'b0, {(WORD_BITS-1){1'b1}}} : q_reg[WORD_BITS-1:0];
        end
        else if (hi_nz && !exact_lim)
        begin
            quo = {1'b1, {(WORD_BITS-1){1'b0}}};
        end
        else
        begin
            quo = -q_reg[WORD_BITS-1:0];
        end
    end

    assign done = done_reg;

endmodule

FILE: hw/rtl/mi4_dp.sv
module mi4_dp #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mi4_pkg::cmd_t        cmd,
    output mi4_pkg::sts_t        sts,
    input  logic [WORD_BITS-1:0] value_in,
    input  logic [30:0]          eps,
    output logic                 result_valid,
    output logic [WORD_BITS-1:0] value_out,
    output logic [3:0]           element_index,
    output logic                 singular,
    output logic                 last
);

    localparam int P     = 2 * WORD_BITS + 2;
    localparam int ACC_W = 4 * WORD_BITS + 8;
    localparam int EW    = (WORD_BITS > 31) ? WORD_BITS : 31;
    localparam int SH_W  = WORD_BITS + 3 * FRAC_BITS;
    localparam int CMP_W = ((ACC_W > SH_W) ? ACC_W : SH_W) + 1;

    logic [WORD_BITS-1:0]    elem_reg [16];
    logic signed [P-1:0]     mid_reg [mi4_pkg::MID_COUNT];
    logic [2*P-1:0]          mcand_reg;
    logic [P-1:0]            mplier_reg;
    logic                    sign_a_reg;
    logic                    neg_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] det_reg;

    logic                    valid_reg;
    logic [WORD_BITS-1:0]    value_reg;
    logic [3:0]              index_reg;
    logic                    sing_reg;
    logic                    last_reg;

    logic signed [P-1:0]     opnd;
    logic [P-1:0]            opnd_mag;
    logic [4:0]              mid_code;
    logic [3:0]              mid_sel;
    logic [ACC_W-1:0]        det_mag;
    logic [EW-1:0]           eps_ext;
    logic [WORD_BITS-1:0]    eps_word;
    logic [CMP_W-1:0]        eps_sh;
    logic [WORD_BITS-1:0]    div_quo;
    logic                    div_done;

    // Operand select: stored elements sign-extended, or an intermediate vector.
    assign mid_code = cmd.sel - mi4_pkg::OPD_MID_BASE;
    assign mid_sel  = mid_code[3:0];

    always_comb
    begin
        if (!cmd.sel[4])
        begin
            opnd = P'($signed(elem_reg[cmd.sel[3:0]]));
        end
        else if (mid_code < 5'(mi4_pkg::MID_COUNT))
        begin
            opnd = mid_reg[mid_sel];
        end
        else
        begin
            opnd = '0;
        end
        opnd_mag = opnd[P-1] ? P'(-opnd) : P'(opnd);
    end

    // Element store, written as items arrive.
    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            elem_reg[cmd.load_idx] <= value_in;
        end
    end

    // Intermediate vectors and the determinant.
    always_ff @(posedge clk)
    begin
        if (cmd.commit_mid)
        begin
            mid_reg[cmd.mid_idx] <= acc_reg[P-1:0];
        end
        if (cmd.commit_det)
        begin
            det_reg <= acc_reg;
        end
    end

    // Shift-add multiplier operands, one multiplier bit per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.ld_a)
        begin
            mcand_reg  <= (2*P)'(opnd_mag);
            sign_a_reg <= opnd[P-1];
        end
        else if (cmd.mul_step)
        begin
            mcand_reg <= {mcand_reg[2*P-2:0], 1'b0};
        end
        if (cmd.ld_b)
        begin
            mplier_reg <= opnd_mag;
            neg_reg    <= sign_a_reg ^ opnd[P-1] ^ cmd.neg;
        end
        else if (cmd.mul_step)
        begin
            mplier_reg <= {1'b0, mplier_reg[P-1:1]};
        end
    end

    // Accumulator: each partial product is added or subtracted directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.mul_step && mplier_reg[0])
        begin
            if (neg_reg)
            begin
                acc_reg <= acc_reg - $signed(ACC_W'(mcand_reg));
            end
            else
            begin
                acc_reg <= acc_reg + $signed(ACC_W'(mcand_reg));
            end
        end
    end

    // Singular test: a threshold that is negative in the word format always trips it.
    assign det_mag  = det_reg[ACC_W-1] ? ACC_W'(-det_reg) : ACC_W'(det_reg);
    assign eps_ext  = EW'(eps);
    assign eps_word = eps_ext[WORD_BITS-1:0];
    assign eps_sh   = CMP_W'(eps_word) << (3 * FRAC_BITS);
    assign sts.singular = (det_reg == '0) || eps_word[WORD_BITS-1]
                          || (CMP_W'(det_mag) < eps_sh);
    assign sts.div_done = div_done;

    mi4_div #(
        .WORD_BITS(WORD_BITS),
        .FRAC_BITS(FRAC_BITS),
        .ACC_W    (ACC_W)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.div_start),
        .cof  (acc_reg),
        .det  (det_reg),
        .quo  (div_quo),
        .done (div_done)
    );

    // Result register: each item is shown for one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit_cof || cmd.emit_echo;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_cof || cmd.emit_echo)
        begin
            value_reg <= cmd.emit_echo ? elem_reg[cmd.sel[3:0]] : div_quo;
            index_reg <= cmd.idx;
            sing_reg  <= cmd.emit_echo;
            last_reg  <= (cmd.idx == mi4_pkg::LAST_IDX);
        end
    end

    assign result_valid  = valid_reg;
    assign value_out     = value_reg;
    assign element_index = index_reg;
    assign singular      = sing_reg;
    assign last          = last_reg;

endmodule

FILE: hw/rtl/mi4_ctrl.sv
module mi4_ctrl #(
    parameter int WORD_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output mi4_pkg::cmd_t cmd,
    input  mi4_pkg::sts_t sts
);

    localparam int P    = 2 * WORD_BITS + 2;
    localparam int CW   = $clog2(P + 1);

    mi4_pkg::state_t state_reg, state_next;
    logic [6:0]      pc_reg, pc_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [3:0]      idx_reg, idx_next;
    logic [3:0]      load_cnt_reg, load_cnt_next;
    mi4_pkg::mop_t   mop;

    assign mop  = mi4_pkg::micro_op(pc_reg);
    assign busy = (state_reg != mi4_pkg::ST_LOAD);

    // Next state and counters.
    always_comb
    begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        load_cnt_next = load_cnt_reg;
        case (state_reg)
            mi4_pkg::ST_LOAD:
            begin
                pc_next  = '0;
                idx_next = '0;
                if (start)
                begin
                    load_cnt_next = load_cnt_reg + 1'b1;
                    if (load_cnt_reg == mi4_pkg::LAST_IDX)
                    begin
                        state_next = mi4_pkg::ST_OPA;
                    end
                end
            end
            mi4_pkg::ST_OPA:
            begin
                state_next = mi4_pkg::ST_OPB;
            end
            mi4_pkg::ST_OPB:
            begin
                cnt_next   = CW'(P);
                state_next = mi4_pkg::ST_MUL;
            end
            mi4_pkg::ST_MUL:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = mi4_pkg::ST_COMMIT;
                end
            end
            mi4_pkg::ST_COMMIT:
            begin
                case (mop.dest)
                    mi4_pkg::DST_DET:
                    begin
                        state_next = mi4_pkg::ST_CHECK;
                    end
                    mi4_pkg::DST_COF:
                    begin
                        state_next = mi4_pkg::ST_DIV;
                    end
                    default:
                    begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = mi4_pkg::ST_OPA;
                    end
                endcase
            end
            mi4_pkg::ST_CHECK:
            begin
                if (sts.singular)
                begin
                    state_next = mi4_pkg::ST_ECHO;
                end
                else
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = mi4_pkg::ST_OPA;
                end
            end
            mi4_pkg::ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = mi4_pkg::ST_EMIT;
                end
            end
            mi4_pkg::ST_EMIT:
            begin
                idx_next = idx_reg + 1'b1;
                pc_next  = pc_reg + 1'b1;
                state_next = (idx_reg == mi4_pkg::LAST_IDX) ? mi4_pkg::ST_LOAD : mi4_pkg::ST_OPA;
            end
            mi4_pkg::ST_ECHO:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == mi4_pkg::LAST_IDX)
                begin
                    state_next = mi4_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = mi4_pkg::ST_LOAD;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd            = '0;
        cmd.load_we    = (state_reg == mi4_pkg::ST_LOAD) && start;
        cmd.load_idx   = load_cnt_reg;
        cmd.neg        = mop.neg;
        cmd.mid_idx    = mop.mid;
        cmd.idx        = idx_reg;
        case (state_reg)
            mi4_pkg::ST_OPA:
            begin
                cmd.sel  = mop.a;
                cmd.ld_a = 1'b1;
            end
            mi4_pkg::ST_OPB:
            begin
                cmd.sel  = mop.b;
                cmd.ld_b = 1'b1;
            end
            mi4_pkg::ST_MUL:
            begin
                cmd.mul_step = 1'b1;
            end
            mi4_pkg::ST_COMMIT:
            begin
                cmd.acc_clr    = (mop.dest != mi4_pkg::DST_NONE);
                cmd.commit_mid = (mop.dest == mi4_pkg::DST_MID);
                cmd.commit_det = (mop.dest == mi4_pkg::DST_DET);
                cmd.div_start  = (mop.dest == mi4_pkg::DST_COF);
            end
            mi4_pkg::ST_EMIT:
            begin
                cmd.emit_cof = 1'b1;
            end
            mi4_pkg::ST_ECHO:
            begin
                cmd.sel       = {1'b0, idx_reg};
                cmd.emit_echo = 1'b1;
            end
            default:
            begin
                cmd.sel = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mi4_pkg::ST_LOAD;
            pc_reg       <= '0;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            load_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            load_cnt_reg <= load_cnt_next;
        end
    end

`ifndef SYNTHESIS
    // The sixteenth emitted element ends the matrix.
    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mi4_pkg::ST_EMIT && idx_reg == mi4_pkg::LAST_IDX)
        |=> state_reg == mi4_pkg::ST_LOAD)
        else $error("emit of last element did not return to load");

    // The singular decision is taken exactly at the determinant step.
    a_check_pc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mi4_pkg::ST_CHECK |-> pc_reg == mi4_pkg::DET_PC)
        else $error("determinant check at wrong program step");

    // The program never runs past its last step.
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mi4_pkg::ST_MUL |-> pc_reg <= mi4_pkg::LAST_PC)
        else $error("program counter out of range");

    // A quotient completes only while the controller waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> state_reg == mi4_pkg::ST_DIV)
        else $error("divider finished outside of division wait");
`endif

endmodule

FILE: hw/rtl/matrix_inverse_4x4_unit.sv
// A regular matrix computes its products with the bit-serial multiplier and its
// sixteen cofactors with the restoring divider; a singular one stops after the
// determinant and echoes its inputs instead. Items are taken one per cycle while start
// is high and busy is low.
// Results appear one cycle each and cannot be stalled.
// Reset (rst_n, asynchronous, active low) clears the load count and sets the epsilon to 1.
module matrix_inverse_4x4_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] value_in,
    output logic                 busy,
    output logic                 result_valid,
    output logic [WORD_BITS-1:0] value_out,
    output logic [3:0]           element_index,
    output logic                 singular,
    output logic                 last
);

    logic [30:0]   eps_reg;
    mi4_pkg::cmd_t cmd;
    mi4_pkg::sts_t sts;

    // Configuration register: singular epsilon at byte address 0.
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {1'b0, eps_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= 31'd1;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            eps_reg <= pwdata[30:0];
        end
    end

    mi4_ctrl #(
        .WORD_BITS(WORD_BITS)
    ) u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .cmd  (cmd),
        .sts  (sts)
    );

    mi4_dp #(
        .WORD_BITS(WORD_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .value_in     (value_in),
        .eps          (eps_reg),
        .result_valid (result_valid),
        .value_out    (value_out),
        .element_index(element_index),
        .singular     (singular),
        .last         (last)
    );

endmodule
